// ===== design/dcrs_pkg.sv =====
// Shared types and constants for the delay candidate ranking sorter.
// Used by dcrs_divider, dcrs_cell and delay_candidate_ranking_sorter.
package dcrs_pkg;

    localparam int CANDIDATES_DEF = 64;

    localparam int DELAY_W = 16;
    localparam int ERROR_W = 32;
    localparam int TIME_W  = 32;
    localparam int DIV_W   = 16;
    localparam int DIST_W  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MEASURED_TIME      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIVISOR      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_DISTANCE = 2'd2;

    localparam logic [TIME_W-1:0] RST_MEASURED_TIME      = 32'd0;
    localparam logic [DIV_W-1:0]  RST_SCALE_DIVISOR      = 16'd1;
    localparam logic [DIST_W-1:0] RST_REFERENCE_DISTANCE = 16'd200;

    typedef struct packed {
        logic [DELAY_W-1:0] candidate_delay;
        logic               last_candidate;
    } t_in;

    typedef struct packed {
        logic [DELAY_W-1:0] ranked_delay;
        logic [ERROR_W-1:0] ranked_error;
        logic               last_ranked;
    } t_out;

    typedef struct packed {
        logic               valid;
        logic [ERROR_W-1:0] error;
        logic [DELAY_W-1:0] delay;
    } t_entry;

    typedef struct packed {
        logic               insert;
        logic               shift;
        logic [ERROR_W-1:0] new_error;
        logic [DELAY_W-1:0] new_delay;
    } t_cell_ctl;

endpackage

// ===== design/dcrs_divider.sv =====
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
// Depends on dcrs_pkg for widths.
module dcrs_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dcrs_pkg::TIME_W-1:0]  i_dividend,
    input  logic [dcrs_pkg::DIV_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [dcrs_pkg::TIME_W-1:0]  o_quotient
);
    localparam int CNT_W = $clog2(dcrs_pkg::TIME_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [dcrs_pkg::DIV_W-1:0]    r_rem;
    logic [dcrs_pkg::DIV_W-1:0]    r_div;
    logic [dcrs_pkg::TIME_W-1:0]   r_quo;

    logic [dcrs_pkg::DIV_W:0]      w_trial;
    logic [dcrs_pkg::DIV_W:0]      w_diff;
    logic                          w_bit;
    logic [dcrs_pkg::DIV_W-1:0]    n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[dcrs_pkg::TIME_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_bit   = (w_trial >= {1'b0, r_div});
        n_rem   = w_bit ? w_diff[dcrs_pkg::DIV_W-1:0] : w_trial[dcrs_pkg::DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= (i_divisor == '0) ? dcrs_pkg::DIV_W'(1) : i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[dcrs_pkg::TIME_W-2:0], w_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(dcrs_pkg::TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/dcrs_cell.sv =====
// One sorting cell: holds one (error, delay) entry of the ascending chain.
// Inserts stably from the broadcast value and shifts toward the head on output.
// Depends on dcrs_pkg for t_entry and t_cell_ctl.
module dcrs_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dcrs_pkg::t_cell_ctl   i_ctl,
    input  dcrs_pkg::t_entry      i_prev,
    input  logic                  i_prev_after,
    input  dcrs_pkg::t_entry      i_next,
    output dcrs_pkg::t_entry      o_entry,
    output logic                  o_after
);
    dcrs_pkg::t_entry r_entry;
    logic             w_after;

    // new value lands at or before this cell; equal errors stay ahead
    assign w_after = !r_entry.valid || (r_entry.error > i_ctl.new_error);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end else if (i_ctl.insert && w_after) begin
            if (i_prev_after) begin
                r_entry <= i_prev;
            end else begin
                r_entry <= '{valid: 1'b1, error: i_ctl.new_error, delay: i_ctl.new_delay};
            end
        end
    end

    assign o_entry = r_entry;
    assign o_after = w_after;

endmodule

// ===== design/delay_candidate_ranking_sorter.sv =====
// Delay candidate ranking sorter. Each candidate is accepted, passed through the
// bit-serial divider, has its error registered and is inserted into the chain of
// sorting cells; no new candidate is taken before that insertion is done. After a
// candidate marked last the stored set streams out one result per unstalled cycle in
// ascending error, ties in arrival order; input is stalled until the final result is taken.
// Depends on dcrs_pkg, dcrs_divider, dcrs_cell.
module delay_candidate_ranking_sorter #(
    parameter int CANDIDATES = dcrs_pkg::CANDIDATES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  dcrs_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output dcrs_pkg::t_out                   o_out,
    input  logic                             i_cfg_we,
    input  logic [dcrs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dcrs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int FILL_W = $clog2(CANDIDATES + 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_INS, S_OUT} t_state;

    t_state                          r_state;
    logic [FILL_W-1:0]               r_fill;
    logic                            r_last;
    logic                            r_neg;
    logic [dcrs_pkg::DELAY_W-1:0]    r_delay;
    logic [dcrs_pkg::ERROR_W-1:0]    r_err;
    logic [dcrs_pkg::TIME_W-1:0]     r_measured_time;
    logic [dcrs_pkg::DIV_W-1:0]      r_scale_divisor;
    logic [dcrs_pkg::DIST_W-1:0]     r_reference_distance;

    logic                            w_in_acc;
    logic                            w_out_acc;
    logic [dcrs_pkg::TIME_W:0]       w_diff;
    logic [dcrs_pkg::TIME_W-1:0]     w_mag;
    logic                            w_div_done;
    logic [dcrs_pkg::TIME_W-1:0]     w_quo;
    logic [dcrs_pkg::TIME_W:0]       w_quo_x;
    logic [dcrs_pkg::TIME_W:0]       w_ref_x;
    logic [dcrs_pkg::TIME_W:0]       w_err_x;
    logic [dcrs_pkg::ERROR_W-1:0]    n_err;
    dcrs_pkg::t_cell_ctl             w_ctl;

    dcrs_pkg::t_entry                w_entry [CANDIDATES];
    logic                            w_after [CANDIDATES];
    dcrs_pkg::t_entry                w_prev  [CANDIDATES];
    dcrs_pkg::t_entry                w_next  [CANDIDATES];
    logic                            w_prev_after [CANDIDATES];
    logic [CANDIDATES-1:0]           w_valid;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign w_out_acc   = o_out_valid && !i_out_stall;

    // signed difference and its magnitude for the divider
    always_comb begin
        w_diff = {1'b0, r_measured_time}
               - {{(dcrs_pkg::TIME_W + 1 - dcrs_pkg::DELAY_W){1'b0}}, i_in.candidate_delay};
        w_mag  = w_diff[dcrs_pkg::TIME_W] ? w_diff[dcrs_pkg::TIME_W-1:0] ^ '1
                 : w_diff[dcrs_pkg::TIME_W-1:0];
        if (w_diff[dcrs_pkg::TIME_W]) begin
            w_mag = w_mag + 1'b1;
        end
    end

    dcrs_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_dividend (w_mag),
        .i_divisor  (r_scale_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // error = |ref - dist|, dist = +/- quotient
    always_comb begin
        w_quo_x = {1'b0, w_quo};
        w_ref_x = {{(dcrs_pkg::TIME_W + 1 - dcrs_pkg::DIST_W){1'b0}}, r_reference_distance};
        if (r_neg) begin
            w_err_x = w_ref_x + w_quo_x;
        end else if (w_quo_x >= w_ref_x) begin
            w_err_x = w_quo_x - w_ref_x;
        end else begin
            w_err_x = w_ref_x - w_quo_x;
        end
        n_err = w_err_x[dcrs_pkg::TIME_W] ? '1 : w_err_x[dcrs_pkg::ERROR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measured_time      <= dcrs_pkg::RST_MEASURED_TIME;
            r_scale_divisor      <= dcrs_pkg::RST_SCALE_DIVISOR;
            r_reference_distance <= dcrs_pkg::RST_REFERENCE_DISTANCE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dcrs_pkg::REG_MEASURED_TIME:      r_measured_time <= i_cfg_data;
                dcrs_pkg::REG_SCALE_DIVISOR: begin
                    r_scale_divisor <= i_cfg_data[dcrs_pkg::DIV_W-1:0];
                end
                dcrs_pkg::REG_REFERENCE_DISTANCE: begin
                    r_reference_distance <= i_cfg_data[dcrs_pkg::DIST_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_delay <= i_in.candidate_delay;
                        r_last  <= i_in.last_candidate;
                        r_neg   <= w_diff[dcrs_pkg::TIME_W];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_err   <= n_err;
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    if (r_fill < FILL_W'(CANDIDATES)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= r_last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (w_out_acc && o_out.last_ranked) begin
                        r_fill  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        w_ctl.insert    = (r_state == S_INS) && (r_fill < FILL_W'(CANDIDATES));
        w_ctl.shift     = w_out_acc;
        w_ctl.new_error = r_err;
        w_ctl.new_delay = r_delay;
    end

    genvar g;
    generate
        for (g = 0; g < CANDIDATES; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_prev[g]       = '0;
                assign w_prev_after[g] = 1'b0;
            end else begin : g_body
                assign w_prev[g]       = w_entry[g-1];
                assign w_prev_after[g] = w_after[g-1];
            end
            if (g == CANDIDATES - 1) begin : g_tail
                assign w_next[g] = '0;
            end else begin : g_inner
                assign w_next[g] = w_entry[g+1];
            end
            assign w_valid[g] = w_entry[g].valid;

            dcrs_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_prev       (w_prev[g]),
                .i_prev_after (w_prev_after[g]),
                .i_next       (w_next[g]),
                .o_entry      (w_entry[g]),
                .o_after      (w_after[g])
            );
        end
    endgenerate

    assign o_out.ranked_delay = w_entry[0].delay;
    assign o_out.ranked_error = w_entry[0].error;
    assign o_out.last_ranked  = w_entry[0].valid && !w_entry[1].valid;

    a_out_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> w_entry[0].valid)
        else $error("output offered from an empty chain head");

    a_fill_matches_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_OUT) |-> ($countones(w_valid) == int'(r_fill)))
        else $error("fill count disagrees with occupied cells");

    a_chain_empty_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.last_ranked) |=> !w_entry[0].valid)
        else $error("chain not empty after final transaction");

    a_done_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside division state");

endmodule

// ===== verif/delay_candidate_ranking_sorter_tb.sv =====
// Self-checking testbench for delay_candidate_ranking_sorter: directed and random
// candidate sets under random idling, checked against an in-bench ranking predictor.
// Depends on dcrs_pkg and the delay_candidate_ranking_sorter design sources.
module delay_candidate_ranking_sorter_tb;

    localparam int SLOTS         = dcrs_pkg::CANDIDATES_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 360;
    localparam logic [dcrs_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [dcrs_pkg::DELAY_W-1:0] delay;
        logic [dcrs_pkg::ERROR_W-1:0] error;
    } t_scored;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    dcrs_pkg::t_in                   i_in       = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    dcrs_pkg::t_out                  o_out;
    logic                            i_cfg_we   = 1'b0;
    logic [dcrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [dcrs_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor copy of the link configuration
    logic [dcrs_pkg::TIME_W-1:0] link_time     = dcrs_pkg::RST_MEASURED_TIME;
    logic [dcrs_pkg::DIV_W-1:0]  link_divisor  = dcrs_pkg::RST_SCALE_DIVISOR;
    logic [dcrs_pkg::DIST_W-1:0] link_distance = dcrs_pkg::RST_REFERENCE_DISTANCE;

    t_scored        scored_set[$];
    dcrs_pkg::t_out ranking_due[$];
    dcrs_pkg::t_in  pending_cands[$];

    int  mismatches  = 0;
    int  in_gap_left = 0;
    int  stall_left  = 0;
    bit  steady_run  = 1'b0;

    delay_candidate_ranking_sorter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [dcrs_pkg::ERROR_W-1:0] distance_error(
        logic [dcrs_pkg::DELAY_W-1:0] delay
    );
        longint diff;
        longint divisor;
        longint quot;
        longint err;
        diff    = $signed({32'd0, link_time}) - $signed({48'd0, delay});
        divisor = (link_divisor == '0) ? 64'sd1 : $signed({48'd0, link_divisor});
        quot    = diff / divisor;
        err     = $signed({48'd0, link_distance}) - quot;
        if (err < 0) begin
            err = -err;
        end
        if (err > 64'sh0000_0000_FFFF_FFFF) begin
            err = 64'sh0000_0000_FFFF_FFFF;
        end
        return err[dcrs_pkg::ERROR_W-1:0];
    endfunction

    // stable insertion sort of the held set, then queue the ranked transactions
    task automatic release_ranking();
        t_scored        key;
        dcrs_pkg::t_out res;
        int             j;
        for (int i = 1; i < scored_set.size(); i++) begin
            key = scored_set[i];
            j = i;
            while (j > 0 && scored_set[j-1].error > key.error) begin
                scored_set[j] = scored_set[j-1];
                j--;
            end
            scored_set[j] = key;
        end
        for (int k = 0; k < scored_set.size(); k++) begin
            res.ranked_delay = scored_set[k].delay;
            res.ranked_error = scored_set[k].error;
            res.last_ranked  = (k == scored_set.size() - 1);
            ranking_due.push_back(res);
        end
        scored_set.delete();
    endtask

    task automatic score_candidate(dcrs_pkg::t_in item);
        t_scored entry;
        if (scored_set.size() < SLOTS) begin
            entry.delay = item.candidate_delay;
            entry.error = distance_error(item.candidate_delay);
            scored_set.push_back(entry);
        end
        if (item.last_candidate) begin
            release_ranking();
        end
    endtask

    task automatic check_ranked(dcrs_pkg::t_out got);
        dcrs_pkg::t_out want;
        if (ranking_due.size() == 0) begin
            $error("unexpected ranked transaction: delay %0d error %0d last %0d",
                   got.ranked_delay, got.ranked_error, got.last_ranked);
            mismatches++;
        end else begin
            want = ranking_due.pop_front();
            if (got.ranked_delay !== want.ranked_delay) begin
                $error("ranked_delay: expected %0d, actual %0d",
                       want.ranked_delay, got.ranked_delay);
                mismatches++;
            end
            if (got.ranked_error !== want.ranked_error) begin
                $error("ranked_error: expected %0d, actual %0d",
                       want.ranked_error, got.ranked_error);
                mismatches++;
            end
            if (got.last_ranked !== want.last_ranked) begin
                $error("last_ranked: expected %0d, actual %0d",
                       want.last_ranked, got.last_ranked);
                mismatches++;
            end
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap_left = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                score_candidate(i_in);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap_left > 0) begin
                    in_gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_cands.size() > 0 && !steady_run &&
                             $urandom_range(0, 4) == 0) begin
                    in_gap_left = $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else if (pending_cands.size() > 0) begin
                    i_in       <= pending_cands.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and stall generator
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_ranked(o_out);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!steady_run && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic [dcrs_pkg::CFG_IDX_W-1:0] idx,
                             logic [dcrs_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            dcrs_pkg::REG_MEASURED_TIME:      link_time     = data;
            dcrs_pkg::REG_SCALE_DIVISOR:      link_divisor  = data[dcrs_pkg::DIV_W-1:0];
            dcrs_pkg::REG_REFERENCE_DISTANCE: link_distance = data[dcrs_pkg::DIST_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_cands.size() > 0 || i_in_valid || ranking_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_cand(logic [dcrs_pkg::DELAY_W-1:0] delay, logic last);
        dcrs_pkg::t_in item;
        item.candidate_delay = delay;
        item.last_candidate  = last;
        pending_cands.push_back(item);
    endtask

    function automatic logic [dcrs_pkg::CFG_DATA_W-1:0] upper_noise(logic [15:0] v);
        logic [31:0] r;
        r = $urandom();
        return {r[31:16], v};
    endfunction

    function automatic logic [dcrs_pkg::DELAY_W-1:0] pick_delay();
        case ($urandom_range(0, 3))
            0:       return dcrs_pkg::DELAY_W'($urandom_range(0, 65535));
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2:       return 16'($urandom_range(0, 7) * 8);
            default: return dcrs_pkg::DELAY_W'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic logic [dcrs_pkg::TIME_W-1:0] pick_time();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return $urandom();
            default: return $urandom_range(0, 300000);
        endcase
    endfunction

    function automatic logic [15:0] pick_divisor();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(2, 4096));
        endcase
    endfunction

    function automatic logic [15:0] pick_reference();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd200;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        int  random_sent;
        int  set_size;
        bit  overflow_done;
        random_sent   = 0;
        overflow_done = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: lone last candidate, then delay extremes
        push_cand(16'd0, 1'b1);
        wait_drained();
        push_cand(16'hFFFF, 1'b0);
        push_cand(16'd0, 1'b0);
        push_cand(16'h8000, 1'b0);
        push_cand(16'd1, 1'b1);
        wait_drained();

        // wide divisor: equal errors must keep arrival order
        write_reg(dcrs_pkg::REG_MEASURED_TIME, 32'd100000);
        write_reg(dcrs_pkg::REG_SCALE_DIVISOR, 32'd1000);
        write_reg(dcrs_pkg::REG_REFERENCE_DISTANCE, 32'd100);
        push_cand(16'd500, 1'b0);
        push_cand(16'd0, 1'b0);
        push_cand(16'd999, 1'b0);
        push_cand(16'd1000, 1'b0);
        push_cand(16'd400, 1'b0);
        push_cand(16'hFFFF, 1'b1);
        wait_drained();

        // zero divisor acts as one; largest error
        write_reg(dcrs_pkg::REG_SCALE_DIVISOR, 32'd0);
        write_reg(dcrs_pkg::REG_MEASURED_TIME, 32'hFFFF_FFFF);
        write_reg(dcrs_pkg::REG_REFERENCE_DISTANCE, 32'd0);
        push_cand(16'd0, 1'b0);
        push_cand(16'hFFFF, 1'b0);
        push_cand(16'd12345, 1'b1);
        wait_drained();

        // unmapped index is ignored; top divisor and distance
        write_reg(REG_UNMAPPED, $urandom());
        write_reg(dcrs_pkg::REG_SCALE_DIVISOR, 32'hFFFF_FFFF);
        write_reg(dcrs_pkg::REG_REFERENCE_DISTANCE, 32'h0000_FFFF);
        write_reg(dcrs_pkg::REG_MEASURED_TIME, 32'd0);
        push_cand(16'hFFFE, 1'b0);
        push_cand(16'hFFFF, 1'b0);
        push_cand(16'd3, 1'b1);
        wait_drained();

        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= RANDOM_ITEMS * 5 / 6) begin
                steady_run = 1'b1;
            end
            write_reg(dcrs_pkg::REG_MEASURED_TIME, pick_time());
            write_reg(dcrs_pkg::REG_SCALE_DIVISOR, upper_noise(pick_divisor()));
            write_reg(dcrs_pkg::REG_REFERENCE_DISTANCE, upper_noise(pick_reference()));
            if ($urandom_range(0, 5) == 0) begin
                write_reg(REG_UNMAPPED, $urandom());
            end
            repeat ($urandom_range(2, 5)) begin
                if (!overflow_done) begin
                    // more candidates than slots: the extras are dropped
                    set_size = SLOTS + 2;
                    overflow_done = 1'b1;
                end else if ($urandom_range(0, 11) == 0) begin
                    set_size = $urandom_range(SLOTS - 4, SLOTS + 6);
                end else begin
                    set_size = $urandom_range(1, 12);
                end
                for (int n = 0; n < set_size; n++) begin
                    push_cand(pick_delay(), n == set_size - 1);
                end
                random_sent += set_size;
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("delay_candidate_ranking_sorter_tb passed");
        end else begin
            $display("delay_candidate_ranking_sorter_tb failed");
        end
        $finish;
    end

    initial begin
        #(12 * 400_000);
        $display("delay_candidate_ranking_sorter_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dcrs_pkg.sv
design/dcrs_divider.sv
design/dcrs_cell.sv
design/delay_candidate_ranking_sorter.sv
verif/delay_candidate_ranking_sorter_tb.sv
